// ===== rtl/slfe_pkg.sv =====
// ----------------------------------------------------------------------------
// slfe_pkg: shared types and constants for the sync/length frame extractor
// Holds the parser phase type, the result record and the framing constants.
// ----------------------------------------------------------------------------
package slfe_pkg;

  localparam int BUFFER_BYTES = 64;
  localparam int TAIL_RESERVE = 3;

  // A window closes once this many bytes have been captured.
  localparam logic [7:0] CAP_LIMIT = 8'(BUFFER_BYTES - TAIL_RESERVE);

  localparam logic [7:0]  SYNC_FIRST    = 8'h55;
  localparam logic [7:0]  SYNC_SECOND   = 8'hAA;
  localparam logic [7:0]  STOP_BYTE     = 8'h0A;
  localparam logic [15:0] TIMEOUT_RESET = 16'd50;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_CLOSE = 1'b1;

  // Result queue: an item gives at most two results.
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_SAW55   = 3'd1,
    PH_LENGTH  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_DONE    = 3'd4
  } phase_t;

  typedef struct packed {
    logic       result_kind;
    logic [5:0] slot_index;
    logic [7:0] slot_value;
    logic       frame_seen;
    logic [5:0] window_bytes;
    logic       last_of_run;
  } result_t;

endpackage

// ===== rtl/sync_length_frame_extractor.sv =====
// ----------------------------------------------------------------------------
// sync_length_frame_extractor: UART receive window framer
// Groups received bytes and idle ticks into windows, finds the first
// 0x55,0xAA,length frame, emits payload slot writes and a closure report.
// ----------------------------------------------------------------------------
// Results are registered in the result queue before they are offered.
// Throughput: one request per cycle while in_stall is low; a request that yields
//   two results puts both into the queue, and the four-entry result queue sets how long
//   the input keeps flowing while the output is stalled.
// Reset: synchronous, active low; clears the window state, empties the queue
//   and sets the idle timeout to 50 ticks.
module sync_length_frame_extractor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [5:0]  out_slot_index,
  output logic [7:0]  out_slot_value,
  output logic        out_frame_seen,
  output logic [5:0]  out_window_bytes,
  output logic        out_last_of_run
);
  import slfe_pkg::*;

  logic [15:0] timeout_r;
  phase_t      ph_r, ph_upd, ph_nxt;
  logic [15:0] idle_r, idle_nxt, idle_inc;
  logic [7:0]  cap_r, cap_nxt, cap_inc;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  pw_r, pw_nxt, pw_inc;
  logic        muted_r, muted_nxt, muted_upd;

  logic acc;
  logic wr_fire;
  logic close_fire;
  logic seen;

  result_t    res0, res1;
  logic [1:0] push_cnt;

  result_t               queue_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]     cnt_r, cnt_nxt;
  logic                  pop;

  assign acc      = in_valid && !in_stall;
  assign idle_inc = idle_r + 16'd1;
  assign cap_inc  = cap_r + 8'd1;
  assign pw_inc   = pw_r + 8'd1;

  // Window state and parser phase.
  always_comb begin
    ph_upd     = ph_r;
    idle_nxt   = idle_r;
    cap_nxt    = cap_r;
    len_nxt    = len_r;
    pw_nxt     = pw_r;
    muted_upd  = muted_r;
    wr_fire    = 1'b0;
    close_fire = 1'b0;
    if (acc) begin
      if (in_action == ACT_TICK) begin
        idle_nxt   = idle_inc;
        close_fire = (idle_inc >= timeout_r);
      end else begin
        // A window that opens with a zero byte is ignored until it closes.
        muted_upd = muted_r || (cap_r == 8'd0 && in_rx_byte == 8'd0);
        cap_nxt   = cap_inc;
        if (!muted_upd) begin
          unique case (ph_r)
            PH_HUNT: begin
              if (in_rx_byte == SYNC_FIRST) ph_upd = PH_SAW55;
            end
            PH_SAW55: begin
              if (in_rx_byte == SYNC_SECOND) ph_upd = PH_LENGTH;
              else if (in_rx_byte != SYNC_FIRST) ph_upd = PH_HUNT;
            end
            PH_LENGTH: begin
              len_nxt = in_rx_byte;
              ph_upd  = (in_rx_byte <= 8'd1) ? PH_DONE : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
              if (in_rx_byte == STOP_BYTE) begin
                ph_upd = PH_DONE;
              end else begin
                wr_fire = 1'b1;
                pw_nxt  = pw_inc;
                if ({1'b0, pw_inc} + 9'd1 >= {1'b0, len_r}) ph_upd = PH_DONE;
              end
            end
            default: begin
            end
          endcase
        end
        close_fire = (cap_inc >= CAP_LIMIT);
      end
    end
  end

  assign seen = (ph_upd == PH_PAYLOAD) || (ph_upd == PH_DONE);

  always_comb begin
    ph_nxt    = ph_upd;
    muted_nxt = muted_upd;
    if (close_fire) begin
      ph_nxt    = PH_HUNT;
      muted_nxt = 1'b0;
    end
  end

  // Result records for this request.
  always_comb begin
    result_t wr_res, cl_res;
    wr_res = '0;
    wr_res.result_kind = KIND_WRITE;
    wr_res.slot_index  = pw_r[5:0];
    wr_res.slot_value  = in_rx_byte;
    cl_res = '0;
    cl_res.result_kind  = KIND_CLOSE;
    cl_res.frame_seen   = seen;
    cl_res.window_bytes = cap_nxt[5:0];
    cl_res.last_of_run  = 1'b1;
    res0     = '0;
    res1     = cl_res;
    push_cnt = 2'd0;
    if (wr_fire && close_fire) begin
      res0     = wr_res;
      push_cnt = 2'd2;
    end else if (wr_fire) begin
      res0             = wr_res;
      res0.last_of_run = 1'b1;
      push_cnt         = 2'd1;
    end else if (close_fire) begin
      res0     = cl_res;
      push_cnt = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
      ph_r      <= PH_HUNT;
      idle_r    <= '0;
      cap_r     <= '0;
      len_r     <= '0;
      pw_r      <= '0;
      muted_r   <= 1'b0;
    end else begin
      if (cfg_we) timeout_r <= cfg_wdata;
      ph_r    <= ph_nxt;
      muted_r <= muted_nxt;
      if (close_fire) begin
        idle_r <= '0;
        cap_r  <= '0;
        len_r  <= '0;
        pw_r   <= '0;
      end else begin
        idle_r <= idle_nxt;
        cap_r  <= cap_nxt;
        len_r  <= len_nxt;
        pw_r   <= pw_nxt;
      end
    end
  end

  // Result queue: up to two writes and one read per cycle.
  assign pop      = out_valid && !out_stall;
  assign cnt_nxt  = cnt_r + {{(QUEUE_AW-1){1'b0}}, push_cnt} - {{QUEUE_AW{1'b0}}, pop};
  assign in_stall = (cnt_r > (QUEUE_AW+1)'(QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QUEUE_AW'(push_cnt);
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) queue_r[wr_ptr_r] <= res0;
    if (push_cnt == 2'd2) queue_r[wr_ptr_r + 1'b1] <= res1;
  end

  assign out_valid        = (cnt_r != '0);
  assign out_result_kind  = queue_r[rd_ptr_r].result_kind;
  assign out_slot_index   = queue_r[rd_ptr_r].slot_index;
  assign out_slot_value   = queue_r[rd_ptr_r].slot_value;
  assign out_frame_seen   = queue_r[rd_ptr_r].frame_seen;
  assign out_window_bytes = queue_r[rd_ptr_r].window_bytes;
  assign out_last_of_run  = queue_r[rd_ptr_r].last_of_run;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QUEUE_AW+1)'(QUEUE_DEPTH))
    else $error("result queue overfilled");

  a_cap_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cap_r < CAP_LIMIT)
    else $error("captured count reached the window limit without closing");

  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    close_fire |=> (cap_r == 8'd0 && idle_r == 16'd0 && ph_r == PH_HUNT))
    else $error("window state not cleared after closure");

  a_muted_silent: assert property (@(posedge clk) disable iff (!rst_n)
    muted_r |-> !wr_fire)
    else $error("payload write in a muted window");

endmodule

// ===== tb/sync_length_frame_extractor_tb.sv =====
// ----------------------------------------------------------------------------
// sync_length_frame_extractor_tb: self-checking bench for the frame extractor
// A short directed table, then random receive windows built from sync pairs,
// length bytes, payload, noise and idle ticks. A behavioral model of the framer
// predicts payload writes and window closures; typed rows give their own result.
// ----------------------------------------------------------------------------
module sync_length_frame_extractor_tb;
  import slfe_pkg::*;

  localparam int NUM_PHASES    = 9;
  localparam int PHASE_REQS    = 190;
  localparam int RESET_ROWS    = 2;
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic       act;
    logic [7:0] data;
    logic [7:0] reps;
    logic       typed;
    result_t    want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_action = 1'b0;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_result_kind;
  logic [5:0]  out_slot_index;
  logic [7:0]  out_slot_value;
  logic        out_frame_seen;
  logic [5:0]  out_window_bytes;
  logic        out_last_of_run;

  sync_length_frame_extractor dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_slot_index   (out_slot_index),
    .out_slot_value   (out_slot_value),
    .out_frame_seen   (out_frame_seen),
    .out_window_bytes (out_window_bytes),
    .out_last_of_run  (out_last_of_run)
  );

  // Framer model state.
  logic [15:0] tmo_reg;
  phase_t      phase;
  logic [15:0] idle_cnt;
  logic [7:0]  cap_cnt;
  logic [7:0]  decl_len;
  logic [7:0]  paid;
  logic        muted;
  bit          win_closed;

  result_t   pending_results [$];
  stim_row_t dir_rows [$];
  int        err_cnt = 0;
  int        req_cnt = 0;
  int        snd_idle = 0;
  int        rcv_idle = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic void clear_window();
    phase    = PH_HUNT;
    idle_cnt = '0;
    cap_cnt  = '0;
    decl_len = '0;
    paid     = '0;
    muted    = 1'b0;
  endfunction

  function automatic result_t mk_close(logic seen, logic [5:0] nbytes);
    result_t c;
    c              = '0;
    c.result_kind  = KIND_CLOSE;
    c.frame_seen   = seen;
    c.window_bytes = nbytes;
    c.last_of_run  = 1'b1;
    return c;
  endfunction

  function automatic result_t close_window();
    result_t c;
    c = mk_close(phase >= PH_PAYLOAD, cap_cnt[5:0]);
    c.last_of_run = 1'b0;
    clear_window();
    win_closed = 1'b1;
    return c;
  endfunction

  // Advances the framer by one request and returns the results it causes.
  task automatic frame_step(input logic act, input logic [7:0] b, output int n,
                            output result_t r0, output result_t r1);
    result_t rs [2];
    n = 0;
    rs[0] = '0;
    rs[1] = '0;
    if (act == ACT_TICK) begin
      idle_cnt = idle_cnt + 16'd1;
      if (idle_cnt >= tmo_reg) begin
        rs[n] = close_window();
        n++;
      end
    end else begin
      if (cap_cnt == 8'd0 && b == 8'd0) muted = 1'b1;
      cap_cnt = cap_cnt + 8'd1;
      if (!muted) begin
        case (phase)
          PH_HUNT: begin
            if (b == SYNC_FIRST) phase = PH_SAW55;
          end
          PH_SAW55: begin
            if (b == SYNC_SECOND) phase = PH_LENGTH;
            else if (b != SYNC_FIRST) phase = PH_HUNT;
          end
          PH_LENGTH: begin
            decl_len = b;
            if (b <= 8'd1) phase = PH_DONE;
            else phase = PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            if (b == STOP_BYTE) begin
              phase = PH_DONE;
            end else begin
              rs[n] = '0;
              rs[n].result_kind = KIND_WRITE;
              rs[n].slot_index  = paid[5:0];
              rs[n].slot_value  = b;
              n++;
              paid = paid + 8'd1;
              // The comparison is done one bit wider so that 255 written does not wrap.
              if ({1'b0, paid} + 9'd1 >= {1'b0, decl_len}) phase = PH_DONE;
            end
          end
          default: begin
          end
        endcase
      end
      if (cap_cnt >= CAP_LIMIT) begin
        rs[n] = close_window();
        n++;
      end
    end
    if (n > 0) rs[n-1].last_of_run = 1'b1;
    r0 = rs[0];
    r1 = rs[1];
  endtask

  task automatic send_req(input logic act, input logic [7:0] b, input logic typed,
                          input result_t want);
    int      n;
    result_t r0, r1;
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_action  <= act;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frame_step(act, b, n, r0, r1);
    if (typed) begin
      pending_results.push_back(want);
    end else begin
      if (n > 0) pending_results.push_back(r0);
      if (n > 1) pending_results.push_back(r1);
    end
    req_cnt++;
  endtask

  task automatic push_byte(input logic [7:0] b);
    send_req(ACT_BYTE, b, 1'b0, '0);
  endtask

  task automatic push_tick();
    send_req(ACT_TICK, 8'($urandom_range(255)), 1'b0, '0);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we  <= 1'b0;
    tmo_reg = v;
  endtask

  function automatic void add_row(logic act, logic [7:0] data, logic [7:0] reps,
                                  logic typed, result_t want);
    stim_row_t r;
    r.act   = act;
    r.data  = data;
    r.reps  = reps;
    r.typed = typed;
    r.want  = want;
    dir_rows.push_back(r);
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(5))
      0: return SYNC_FIRST;
      1: return SYNC_SECOND;
      2: return STOP_BYTE;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // One receive window: optional leading zero, noise, a sync pair (sometimes
  // repeated or broken), a length, payload with stray stops and ticks, maybe a
  // second frame, and then ticks or bytes until the window closes.
  task automatic run_window();
    int len, npay, sel;
    bit fill;
    if ($urandom_range(9) == 0) push_byte(8'h00);
    repeat ($urandom_range(3)) begin
      if ($urandom_range(3) == 0) push_tick();
      else push_byte(noise_byte());
    end
    sel = $urandom_range(99);
    push_byte(SYNC_FIRST);
    if (sel >= 70 && sel < 85) push_byte(SYNC_FIRST);
    if (sel < 85) push_byte(SYNC_SECOND);
    else push_byte(noise_byte());
    sel = $urandom_range(99);
    if (sel < 10) len = $urandom_range(1);
    else if (sel < 80) len = $urandom_range(2, 12);
    else len = $urandom_range(13, 255);
    push_byte(8'(len));
    npay = len + $urandom_range(3);
    if (npay > 70) npay = 70;
    for (int k = 0; k < npay; k++) begin
      sel = $urandom_range(99);
      if (sel < 6) push_byte(STOP_BYTE);
      else if (sel < 14) push_tick();
      else push_byte(8'($urandom_range(255)));
    end
    if ($urandom_range(4) == 0) begin
      push_byte(SYNC_FIRST);
      push_byte(SYNC_SECOND);
      push_byte(8'd3);
      push_byte(8'($urandom_range(255)));
    end
    fill = (tmo_reg > 16'd120) || ($urandom_range(99) < 15);
    win_closed = 1'b0;
    while (!win_closed) begin
      if (fill) push_byte(8'($urandom_range(255)));
      else push_tick();
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got.result_kind  = out_result_kind;
      got.slot_index   = out_slot_index;
      got.slot_value   = out_slot_value;
      got.frame_seen   = out_frame_seen;
      got.window_bytes = out_window_bytes;
      got.last_of_run  = out_last_of_run;
      if (pending_results.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("unexpected result: kind=%0d idx=%0d val=%02h seen=%0d bytes=%0d last=%0d",
                   got.result_kind, got.slot_index, got.slot_value, got.frame_seen,
                   got.window_bytes, got.last_of_run);
      end else begin
        want = pending_results.pop_front();
        if (got.result_kind !== want.result_kind || got.slot_index !== want.slot_index ||
            got.slot_value !== want.slot_value || got.frame_seen !== want.frame_seen ||
            got.window_bytes !== want.window_bytes ||
            got.last_of_run !== want.last_of_run) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS) begin
            $display("mismatch: expected kind=%0d idx=%0d val=%02h seen=%0d bytes=%0d last=%0d",
                     want.result_kind, want.slot_index, want.slot_value, want.frame_seen,
                     want.window_bytes, want.last_of_run);
            $display("          actual   kind=%0d idx=%0d val=%02h seen=%0d bytes=%0d last=%0d",
                     got.result_kind, got.slot_index, got.slot_value, got.frame_seen,
                     got.window_bytes, got.last_of_run);
          end
        end
      end
    end
    out_stall <= ($urandom_range(99) < rcv_idle);
  end

  function automatic logic [15:0] phase_timeout(int p);
    case (p)
      0, 8:    return 16'd1;
      1, 5:    return 16'hFFFF;
      2, 6:    return 16'($urandom_range(2, 200));
      3:       return 16'd0;
      4:       return 16'd8;
      default: return TIMEOUT_RESET;
    endcase
  endfunction

  initial begin : main
    int        p;
    int        stop_at;
    stim_row_t r;
    tmo_reg = TIMEOUT_RESET;
    clear_window();
    win_closed = 1'b0;

    // Rows before RESET_ROWS run with the reset timeout; the rest with a
    // timeout of one tick so that single ticks close windows.
    add_row(ACT_TICK, 8'h00, 8'd49, 1'b0, '0);
    add_row(ACT_TICK, 8'hFF, 8'd1, 1'b1, mk_close(1'b0, 6'd0));
    // Leading zero mutes the whole window, sync pair included.
    add_row(ACT_BYTE, 8'h00, 8'd1, 1'b0, '0);
    add_row(ACT_BYTE, 8'h55, 8'd1, 1'b0, '0);
    add_row(ACT_BYTE, 8'hAA, 8'd1, 1'b0, '0);
    add_row(ACT_BYTE, 8'h05, 8'd1, 1'b0, '0);
    add_row(ACT_BYTE, 8'h11, 8'd1, 1'b0, '0);
    add_row(ACT_TICK, 8'h00, 8'd1, 1'b1, mk_close(1'b0, 6'd5));
    // Repeated sync start, maximum length, stop byte, then an ignored frame.
    add_row(ACT_BYTE, 8'h55, 8'd1, 1'b0, '0);
    add_row(ACT_BYTE, 8'h55, 8'd1, 1'b0, '0);
    add_row(ACT_BYTE, 8'hAA, 8'd1, 1'b0, '0);
    add_row(ACT_BYTE, 8'hFF, 8'd1, 1'b0, '0);
    add_row(ACT_BYTE, 8'h00, 8'd1, 1'b0, '0);
    add_row(ACT_BYTE, 8'hFF, 8'd1, 1'b0, '0);
    add_row(ACT_BYTE, 8'h0A, 8'd1, 1'b0, '0);
    add_row(ACT_BYTE, 8'h55, 8'd1, 1'b0, '0);
    add_row(ACT_BYTE, 8'hAA, 8'd1, 1'b0, '0);
    add_row(ACT_BYTE, 8'h03, 8'd1, 1'b0, '0);
    add_row(ACT_TICK, 8'h00, 8'd1, 1'b0, '0);
    // Length of zero still counts as a frame.
    add_row(ACT_BYTE, 8'h55, 8'd1, 1'b0, '0);
    add_row(ACT_BYTE, 8'hAA, 8'd1, 1'b0, '0);
    add_row(ACT_BYTE, 8'h00, 8'd1, 1'b0, '0);
    add_row(ACT_TICK, 8'h00, 8'd1, 1'b1, mk_close(1'b1, 6'd3));
    // The byte that fills the window gives a write and the closure.
    add_row(ACT_BYTE, 8'h55, 8'd1, 1'b0, '0);
    add_row(ACT_BYTE, 8'hAA, 8'd1, 1'b0, '0);
    add_row(ACT_BYTE, 8'hFF, 8'd1, 1'b0, '0);
    add_row(ACT_BYTE, 8'h80, 8'd58, 1'b0, '0);
    // Window closed before the length byte arrived.
    add_row(ACT_BYTE, 8'h55, 8'd1, 1'b0, '0);
    add_row(ACT_TICK, 8'h00, 8'd1, 1'b1, mk_close(1'b0, 6'd1));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    snd_idle = 31;
    rcv_idle = 54;
    for (int i = 0; i < dir_rows.size(); i++) begin
      if (i == RESET_ROWS) begin
        wait_drain();
        write_timeout(16'd1);
      end
      r = dir_rows[i];
      for (int k = 0; k < r.reps; k++)
        send_req(r.act, r.data, r.typed && (k == r.reps - 1), r.want);
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      case (p / 3)
        0: begin
          snd_idle = 31;
          rcv_idle = 54;
        end
        1: begin
          snd_idle = 54;
          rcv_idle = 31;
        end
        default: begin
          snd_idle = 0;
          rcv_idle = 0;
        end
      endcase
      wait_drain();
      write_timeout(phase_timeout(p));
      stop_at = req_cnt + PHASE_REQS;
      while (req_cnt < stop_at) begin
        run_window();
        // Midway through phase 4, drain the results after each window.
        if (p == 4 && req_cnt > stop_at - PHASE_REQS / 2 && req_cnt < stop_at - 20)
          wait_drain();
      end
    end

    wait_drain();
    repeat (10) @(posedge clk);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
